[sv/alusf_pkg.sv]
// shared types and select codes for the byte alu with status flags
package alusf_pkg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic negative;
        logic overflow;
        logic zero;
        logic carry;
    } t_flags;

    typedef struct packed {
        t_byte  result;
        t_flags flags;
    } t_alu_out;

    localparam int unsigned LOGIC_BIT = 3;
    localparam int unsigned SIGN_BIT  = 7;

    localparam t_byte OP_INC    = 8'h00;
    localparam t_byte OP_SUB    = 8'h60;
    localparam t_byte OP_ADD    = 8'h90;
    localparam t_byte OP_SHL    = 8'hc0;
    localparam t_byte OP_DEC    = 8'hf0;
    localparam t_byte OP_NOT    = 8'h08;
    localparam t_byte OP_XOR    = 8'h68;
    localparam t_byte OP_PASS_B = 8'ha8;
    localparam t_byte OP_AND    = 8'hb8;
    localparam t_byte OP_OR     = 8'he8;

    localparam logic [8:0] SUB_BIAS = 9'h100;
    localparam logic [8:0] DEC_ADD  = 9'h1ff;

endpackage

[sv/alusf_core.sv]
// combinational alu datapath and flag generation
module alusf_core (
    input  alusf_pkg::t_byte    i_alu_select,
    input  alusf_pkg::t_byte    i_operand_a,
    input  alusf_pkg::t_byte    i_operand_b,
    input  logic                i_carry_in,
    output alusf_pkg::t_alu_out o_out
);
    import alusf_pkg::*;

    logic [8:0] w_a9;
    logic [8:0] w_b9;
    logic [8:0] w_nb9;
    logic [8:0] w_cin9;
    logic [8:0] w_sum;
    logic       w_arith;
    logic       w_ovf;

    assign w_a9   = {1'b0, i_operand_a};
    assign w_b9   = {1'b0, i_operand_b};
    assign w_nb9  = {1'b0, ~i_operand_b};
    assign w_cin9 = {8'b0, i_carry_in};

    always_comb begin
        case (i_alu_select)
            OP_INC:    w_sum = w_a9 + w_cin9;
            OP_SUB:    w_sum = w_a9 + w_nb9 + w_cin9 + SUB_BIAS;
            OP_ADD:    w_sum = w_a9 + w_b9 + w_cin9;
            OP_SHL:    w_sum = w_a9 + w_a9 + w_cin9;
            OP_DEC:    w_sum = w_a9 + DEC_ADD + w_cin9;
            OP_NOT:    w_sum = {1'b0, ~i_operand_a};
            OP_XOR:    w_sum = {1'b0, i_operand_a ^ i_operand_b};
            OP_PASS_B: w_sum = w_b9;
            OP_AND:    w_sum = {1'b0, i_operand_a & i_operand_b};
            OP_OR:     w_sum = {1'b0, i_operand_a | i_operand_b};
            default:   w_sum = '0;
        endcase
    end

    always_comb begin
        if (i_alu_select == OP_ADD) begin
            w_ovf = (i_operand_a[SIGN_BIT] ^ w_sum[SIGN_BIT])
                  & (i_operand_b[SIGN_BIT] ^ w_sum[SIGN_BIT]);
        end else if (i_alu_select == OP_SUB) begin
            w_ovf = (i_operand_a[SIGN_BIT] ^ i_operand_b[SIGN_BIT])
                  & (i_operand_a[SIGN_BIT] ^ w_sum[SIGN_BIT]);
        end else begin
            w_ovf = 1'b0;
        end
    end

    assign w_arith = ~i_alu_select[LOGIC_BIT];

    assign o_out.result         = w_sum[7:0];
    assign o_out.flags.negative = w_arith & w_sum[SIGN_BIT];
    assign o_out.flags.overflow = w_ovf;
    assign o_out.flags.zero     = (w_sum[7:0] == 8'h00);
    assign o_out.flags.carry    = w_arith & w_sum[8];

endmodule

[sv/alu_with_status_flags_unit.sv]
// top level: input register, alu datapath and result register with handshakes
// Byte-wide 74181-style ALU with N, V, Z and C flags. One transaction is
// accepted per clock cycle when the output side keeps up; a transaction is
// held first in the input register and then, once the ALU datapath between
// them has computed it, in the result register. While a finished result
// waits for i_ready, the input register still takes a new transaction, so a
// stalled output does not stop the input until both registers are full. The
// unit holds no state besides these registers; carry_in is ignored by the
// logical codes, and unlisted select codes give a zero result with only Z set.
module alu_with_status_flags_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  alusf_pkg::t_byte i_alu_select,
    input  alusf_pkg::t_byte i_operand_a,
    input  alusf_pkg::t_byte i_operand_b,
    input  logic             i_carry_in,
    output logic             o_valid,
    input  logic             i_ready,
    output alusf_pkg::t_byte o_result,
    output logic             o_flag_negative,
    output logic             o_flag_overflow,
    output logic             o_flag_zero,
    output logic             o_flag_carry
);
    import alusf_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    t_byte    r_in_sel;
    t_byte    r_in_a;
    t_byte    r_in_b;
    logic     r_in_cin;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_out r_out;
    t_alu_out w_core;
    logic     w_out_free;
    logic     w_in_free;

    alusf_core u_core (
        .i_alu_select (r_in_sel),
        .i_operand_a  (r_in_a),
        .i_operand_b  (r_in_b),
        .i_carry_in   (r_in_cin),
        .o_out        (w_core)
    );

    assign w_out_free = ~r_out_valid | i_ready;
    assign w_in_free  = ~r_in_valid | w_out_free;

    always_comb begin
        n_in_valid  = w_in_free ? i_valid : r_in_valid;
        n_out_valid = w_out_free ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_valid) begin
            r_in_sel <= i_alu_select;
            r_in_a   <= i_operand_a;
            r_in_b   <= i_operand_b;
            r_in_cin <= i_carry_in;
        end
        if (w_out_free && r_in_valid) begin
            r_out <= w_core;
        end
    end

    assign o_ready         = w_in_free;
    assign o_valid         = r_out_valid;
    assign o_result        = r_out.result;
    assign o_flag_negative = r_out.flags.negative;
    assign o_flag_overflow = r_out.flags.overflow;
    assign o_flag_zero     = r_out.flags.zero;
    assign o_flag_carry    = r_out.flags.carry;

`ifndef SYNTHESIS
    a_zero_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flag_zero == (o_result == 8'h00)))
        else $error("zero flag does not match result");

    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("input register did not advance into empty result register");

    a_logic_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_out_free && r_in_sel[LOGIC_BIT]
            |=> !o_flag_carry && !o_flag_negative)
        else $error("logical operation produced carry or negative flag");

    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_in_valid)
        else $error("valid set after reset");
`endif

endmodule
